// ----- sv/obbfc_pkg.sv -----
// obbfc_pkg: word types and fixed constants for the box frustum culling pipeline
// depends on nothing; imported by obb_frustum_cull_unit
package obbfc_pkg;

  // configuration register file
  localparam int NUM_REGS   = 8;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 64;

  // named register slots of the matrix column 3 (plane base)
  localparam logic [2:0] REG_C3_ROWS01 = 3'd6;
  localparam logic [2:0] REG_C3_ROWS23 = 3'd7;

  // geometry
  localparam int NUM_PLANES = 6;
  localparam int NUM_AXES   = 3;
  localparam int NUM_COMP   = 3;

  // datapath widths
  localparam int ELEM_W = 32;  // matrix element
  localparam int NRM_W  = 33;  // plane component, sum of two elements
  localparam int AXC_W  = 16;  // axis component
  localparam int EXT_W  = 31;  // half extent
  localparam int APR_W  = 49;  // axis component times plane component
  localparam int DOT_W  = 51;  // sum of three of those
  localparam int MAG_W  = 49;  // magnitude of the dot product
  localparam int LO_W   = 24;  // low slice of magnitude
  localparam int HI_W   = MAG_W - LO_W;
  localparam int CPR_W  = 65;  // plane component times center
  localparam int SAT_W  = 63;  // saturated signed value
  localparam int RT_W   = 62;  // saturated nonnegative value

  localparam logic [RT_W-1:0] SAT_MAX = {RT_W{1'b1}};

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [47:0]        axis_u;
    logic [47:0]        axis_v;
    logic [47:0]        axis_n;
    logic [30:0]        half_size_u;
    logic [30:0]        half_size_v;
    logic [30:0]        half_size_n;
    logic [31:0]        prior_access_frame;
    logic               end_of_pass;
  } in_word_t;

  typedef struct packed {
    logic        is_visible;
    logic [31:0] access_frame;
  } out_word_t;

endpackage

// ----- sv/obb_frustum_cull_unit.sv -----
// obb_frustum_cull_unit: six-plane oriented box culling, fully pipelined
// depends on obbfc_pkg (word types, widths, register slots)
//
// usage
//   in_valid/in_ready carry one box word; out_valid/out_ready carry one result
//   word per box, in order. cfg_we/cfg_index/cfg_wdata write one 64-bit matrix
//   register per cycle with no wait; indexes above 7 are dropped. write the
//   matrix only while no box is in flight.
// timing
//   a box is taken every cycle while the output is free or being taken.
//   its result word passes through the input register, which loads at the
//   accepting edge, then five arithmetic stages (products, dot sums, split
//   extent products, scaling, final sums) and the output register.
// reset
//   rst_n low clears all valid bits, the matrix registers and the frame
//   counter. the frame counter steps after each accepted end-of-pass box.
// stall
//   while out_valid is high and out_ready low the whole pipeline holds and
//   in_ready drops; no word is dropped or repeated.
module obb_frustum_cull_unit
  import obbfc_pkg::*;
#(
  parameter int COORD_FRAC_BITS = 16,
  parameter int AXIS_FRAC_BITS  = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_word,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_word,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int SW = 66 + COORD_FRAC_BITS + AXIS_FRAC_BITS;
  localparam int NSTG = 6;

  // clamp a wide signed value to the saturation range
  function automatic logic signed [SAT_W-1:0] sat_w(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] lim;
    lim = signed'({{(SW-RT_W){1'b0}}, SAT_MAX});
    if (v > lim) sat_w = signed'({1'b0, SAT_MAX});
    else if (v < -lim) sat_w = -signed'({1'b0, SAT_MAX});
    else sat_w = v[SAT_W-1:0];
  endfunction

  // handshake and stage enable
  logic adv;
  logic acc;
  logic [NSTG-1:0] vld_r;
  logic out_valid_r;
  out_word_t out_word_r;

  assign adv = !out_valid_r || out_ready;
  assign in_ready = adv;
  assign acc = in_valid && adv;
  assign out_valid = out_valid_r;
  assign out_word = out_word_r;

  // configuration registers
  logic [CFG_DATA_W-1:0] cfg_r [NUM_REGS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) cfg_r[i] <= '0;
    end else if (cfg_we && cfg_index < CFG_IDX_W'(NUM_REGS)) begin
      cfg_r[cfg_index[2:0]] <= cfg_wdata;
    end
  end

  // plane normals and offsets, registered from the matrix
  logic signed [NRM_W-1:0] nrm_r [NUM_PLANES][NUM_COMP];
  logic signed [NRM_W-1:0] w_r [NUM_PLANES];
  logic [NUM_PLANES-1:0]   nz_r;
  logic signed [NRM_W-1:0] nrm_nxt [NUM_PLANES][NUM_COMP];
  logic signed [NRM_W-1:0] w_nxt [NUM_PLANES];
  logic [NUM_PLANES-1:0]   nz_nxt;

  always_comb begin
    logic signed [NRM_W-1:0] base;
    logic signed [NRM_W-1:0] col;
    logic [ELEM_W-1:0] eb;
    logic [ELEM_W-1:0] ec;
    for (int p = 0; p < NUM_PLANES; p++) begin
      for (int j = 0; j < NUM_COMP + 1; j++) begin
        eb = (j < 2) ? cfg_r[REG_C3_ROWS01][(j % 2)*ELEM_W +: ELEM_W]
                     : cfg_r[REG_C3_ROWS23][(j % 2)*ELEM_W +: ELEM_W];
        ec = cfg_r[3'(2*(p/2) + j/2)][(j % 2)*ELEM_W +: ELEM_W];
        base = signed'({eb[ELEM_W-1], eb});
        col = signed'({ec[ELEM_W-1], ec});
        if (j < NUM_COMP) nrm_nxt[p][j] = (p % 2 == 1) ? base - col : base + col;
        else w_nxt[p] = (p % 2 == 1) ? base - col : base + col;
      end
      nz_nxt[p] = (nrm_nxt[p][0] != '0) || (nrm_nxt[p][1] != '0) || (nrm_nxt[p][2] != '0);
    end
  end

  always_ff @(posedge clk) begin
    nrm_r <= nrm_nxt;
    w_r   <= w_nxt;
    nz_r  <= nz_nxt;
  end

  // frame counter, sampled at acceptance
  logic [31:0] frame_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) frame_cnt_r <= '0;
    else if (acc && in_word.end_of_pass) frame_cnt_r <= frame_cnt_r + 32'd1;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
      out_valid_r <= vld_r[NSTG-1];
    end
  end

  // stage 0: input register
  in_word_t in0_r;
  logic [31:0] frm_r [NSTG];
  logic [31:0] pri_r [NSTG];

  always_ff @(posedge clk) begin
    if (adv) begin
      in0_r <= in_word;
      frm_r[0] <= frame_cnt_r;
      pri_r[0] <= in_word.prior_access_frame;
      for (int k = 1; k < NSTG; k++) begin
        frm_r[k] <= frm_r[k-1];
        pri_r[k] <= pri_r[k-1];
      end
    end
  end

  // unpack the box
  logic signed [AXC_W-1:0] ax [NUM_AXES][NUM_COMP];
  logic signed [31:0]      ctr [NUM_COMP];
  logic [EXT_W-1:0]        ext0 [NUM_AXES];

  always_comb begin
    for (int j = 0; j < NUM_COMP; j++) begin
      ax[0][j] = in0_r.axis_u[j*AXC_W +: AXC_W];
      ax[1][j] = in0_r.axis_v[j*AXC_W +: AXC_W];
      ax[2][j] = in0_r.axis_n[j*AXC_W +: AXC_W];
    end
    ctr[0] = in0_r.center_x;
    ctr[1] = in0_r.center_y;
    ctr[2] = in0_r.center_z;
    ext0[0] = in0_r.half_size_u;
    ext0[1] = in0_r.half_size_v;
    ext0[2] = in0_r.half_size_n;
  end

  // stage 1: all component products
  logic signed [APR_W-1:0] apr1_r [NUM_PLANES][NUM_AXES][NUM_COMP];
  logic signed [CPR_W-1:0] cpr1_r [NUM_PLANES][NUM_COMP];
  logic [EXT_W-1:0]        ext1_r [NUM_AXES];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        for (int j = 0; j < NUM_COMP; j++) begin
          for (int a = 0; a < NUM_AXES; a++) apr1_r[p][a][j] <= ax[a][j] * nrm_r[p][j];
          cpr1_r[p][j] <= nrm_r[p][j] * ctr[j];
        end
      end
      ext1_r <= ext0;
    end
  end

  // stage 2: dot product magnitudes, first center sum
  logic [MAG_W-1:0]        mag2_r [NUM_PLANES][NUM_AXES];
  logic signed [SAT_W-1:0] sa2_r [NUM_PLANES];
  logic signed [CPR_W-1:0] cp2_r [NUM_PLANES];
  logic [EXT_W-1:0]        ext2_r [NUM_AXES];

  always_ff @(posedge clk) begin
    logic signed [DOT_W-1:0] d;
    logic signed [SAT_W-1:0] c0;
    logic signed [SAT_W-1:0] c1;
    if (adv) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        for (int a = 0; a < NUM_AXES; a++) begin
          d = DOT_W'(apr1_r[p][a][0]) + DOT_W'(apr1_r[p][a][1]) + DOT_W'(apr1_r[p][a][2]);
          mag2_r[p][a] <= d[DOT_W-1] ? MAG_W'(-d) : MAG_W'(d);
        end
        c0 = sat_w(SW'(cpr1_r[p][0]));
        c1 = sat_w(SW'(cpr1_r[p][1]));
        sa2_r[p] <= sat_w(SW'(c0) + SW'(c1));
        cp2_r[p] <= cpr1_r[p][2];
      end
      ext2_r <= ext1_r;
    end
  end

  // stage 3: split extent products, second center sum
  logic [LO_W+EXT_W-1:0]   lo3_r [NUM_PLANES][NUM_AXES];
  logic [HI_W+EXT_W-1:0]   hi3_r [NUM_PLANES][NUM_AXES];
  logic signed [SAT_W-1:0] s3_r [NUM_PLANES];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        for (int a = 0; a < NUM_AXES; a++) begin
          lo3_r[p][a] <= (LO_W+EXT_W)'(mag2_r[p][a][LO_W-1:0]) * (LO_W+EXT_W)'(ext2_r[a]);
          hi3_r[p][a] <= (HI_W+EXT_W)'(mag2_r[p][a][MAG_W-1:LO_W]) * (HI_W+EXT_W)'(ext2_r[a]);
        end
        s3_r[p] <= sat_w(SW'(sa2_r[p]) + SW'(sat_w(SW'(cp2_r[p]))));
      end
    end
  end

  // stage 4: recombine extent terms, scale center sum and offset
  localparam int TW = HI_W + EXT_W + LO_W + 1;
  logic [RT_W-1:0]         t4_r [NUM_PLANES][NUM_AXES];
  logic signed [SAT_W-1:0] sh4_r [NUM_PLANES];
  logic signed [SAT_W-1:0] ws4_r [NUM_PLANES];

  always_ff @(posedge clk) begin
    logic [TW-1:0] t;
    if (adv) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        for (int a = 0; a < NUM_AXES; a++) begin
          t = (TW'(hi3_r[p][a]) << LO_W) + TW'(lo3_r[p][a]);
          t4_r[p][a] <= (t > TW'(SAT_MAX)) ? SAT_MAX : t[RT_W-1:0];
        end
        sh4_r[p] <= sat_w(SW'(s3_r[p]) <<< AXIS_FRAC_BITS);
        ws4_r[p] <= sat_w(SW'(w_r[p]) <<< (COORD_FRAC_BITS + AXIS_FRAC_BITS));
      end
    end
  end

  // stage 5: extent radius and plane distance
  logic [RT_W-1:0]         r5_r [NUM_PLANES];
  logic signed [SAT_W-1:0] s5_r [NUM_PLANES];

  always_ff @(posedge clk) begin
    logic [RT_W+1:0] rs;
    if (adv) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        rs = (RT_W+2)'(t4_r[p][0]) + (RT_W+2)'(t4_r[p][1]) + (RT_W+2)'(t4_r[p][2]);
        r5_r[p] <= (rs > (RT_W+2)'(SAT_MAX)) ? SAT_MAX : rs[RT_W-1:0];
        s5_r[p] <= sat_w(SW'(sh4_r[p]) + SW'(ws4_r[p]));
      end
    end
  end

  // output register: any nonzero plane with s below -r culls
  always_ff @(posedge clk) begin
    logic [NUM_PLANES-1:0] cull;
    if (adv) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        cull[p] = nz_r[p] && (SW'(s5_r[p]) < -signed'(SW'({1'b0, r5_r[p]})));
      end
      out_word_r.is_visible <= ~|cull;
      out_word_r.access_frame <= (|cull) ? pri_r[NSTG-1] : frm_r[NSTG-1];
    end
  end

`ifndef SYNTH
  // frame counter only moves on an accepted end-of-pass word
  a_frame_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_valid && in_ready && in_word.end_of_pass) |=> $stable(frame_cnt_r))
    else $error("frame counter moved without end of pass");

  // and then moves by exactly one
  a_frame_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_word.end_of_pass) |=>
      frame_cnt_r == 32'($past(frame_cnt_r) + 32'd1))
    else $error("frame counter did not step by one");

  // a stalled pipeline keeps its valid bits
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r) && $stable(out_valid_r))
    else $error("pipeline valid bits changed under stall");

  // in_ready follows the output register state
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !in_ready)
    else $error("input taken while output stalled");
`endif

endmodule
